@@ hdl/bsu_pkg.sv @@
// bsu_pkg: shared types and codes for the bounded stack with undo journal.
// No dependencies; imported by bsu_csr and bounded_stack_with_undo_core.
`default_nettype none

package bsu_pkg;

   localparam int TAG_W    = 32;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 3;
   localparam int QUOTA_W  = 5;
   localparam int CSR_DW   = 32;
   localparam int CSR_AW   = 3;

   localparam logic [QUOTA_W-1:0] QUOTA_RESET = 5'd10;

   // register index (word address)
   localparam logic REG_QUOTA = 1'b0;

   // actions
   localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_UNDO = 2'd2;

   // result codes
   localparam logic [STATUS_W-1:0] RES_PUSHED       = 3'd0;
   localparam logic [STATUS_W-1:0] RES_FULL         = 3'd1;
   localparam logic [STATUS_W-1:0] RES_POPPED       = 3'd2;
   localparam logic [STATUS_W-1:0] RES_EMPTY        = 3'd3;
   localparam logic [STATUS_W-1:0] RES_PUSH_UNDONE  = 3'd4;
   localparam logic [STATUS_W-1:0] RES_POP_UNDONE   = 3'd5;
   localparam logic [STATUS_W-1:0] RES_NOTHING_UNDO = 3'd6;

   // journal entry kinds
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef struct packed {
      logic [TAG_W-1:0] id;
      logic [TAG_W-1:0] first;
      logic [TAG_W-1:0] last;
      logic [TAG_W-1:0] dept;
   } record_type;

   typedef struct packed {
      logic       kind;
      record_type rec;
   } jrnl_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } seq_state_type;

endpackage

`default_nettype wire

@@ hdl/bsu_ram.sv @@
// bsu_ram: simple dual-port synchronous RAM, one write and one read port,
// registered read data. No dependencies.
`default_nettype none

module bsu_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/bsu_csr.sv @@
// bsu_csr: APB-style register port holding the quota register.
// Depends on bsu_pkg.
`default_nettype none

module bsu_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [bsu_pkg::CSR_AW-1:0]   paddr,
   input  wire logic [bsu_pkg::CSR_DW-1:0]   pwdata,
   output      logic [bsu_pkg::CSR_DW-1:0]   prdata,
   output      logic                         pready,
   output      logic [bsu_pkg::QUOTA_W-1:0]  quota
);

   import bsu_pkg::*;

   logic               reg_idx;
   logic               wr_quota;
   logic [QUOTA_W-1:0] quota_ff;
   logic [QUOTA_W-1:0] quota_in;

   assign reg_idx  = paddr[2];
   assign pready   = 1'b1;
   assign wr_quota = psel && penable && pwrite && (reg_idx == REG_QUOTA);
   assign quota_in = wr_quota ? pwdata[QUOTA_W-1:0] : quota_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         quota_ff <= QUOTA_RESET;
      end else begin
         quota_ff <= quota_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == REG_QUOTA) begin
         prdata = {{(CSR_DW-QUOTA_W){1'b0}}, quota_ff};
      end
   end

   assign quota = quota_ff;

endmodule

`default_nettype wire

@@ hdl/bounded_stack_with_undo_core.sv @@
// bounded_stack_with_undo_core: LIFO record store with an undo journal.
// Depends on bsu_pkg, bsu_ram and bsu_csr.
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+--------------------------
//  request  | req_action, req_record_id, req_*_tag          | start & !busy
//  response | rsp_status, rsp_affected_id, rsp_stored_count | rsp_strobe, one cycle
//  csr      | psel penable pwrite paddr pwdata prdata       | write: psel&penable&pwrite
//
// For each word, the accept edge issues reads of the stack top and
// the newest journal slot (registered RAM read data), the next edge writes back and
// registers the response. busy is high for that one execute cycle.
// The response is registered at the execute edge; the receiver cannot
// stall, and a new word may be accepted while the response is showing.
// Reset (synchronous) empties stack and journal and sets quota to 10; RAM
// contents are left as they are, no clearing pass.
`default_nettype none

module bounded_stack_with_undo_core #(
   parameter int CAPACITY      = 16,
   parameter int JOURNAL_DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request
   input  wire logic                                 start,
   output      logic                                 busy,
   input  wire logic [bsu_pkg::ACTION_W-1:0]         req_action,
   input  wire logic [bsu_pkg::TAG_W-1:0]            req_record_id,
   input  wire logic [bsu_pkg::TAG_W-1:0]            req_first_tag,
   input  wire logic [bsu_pkg::TAG_W-1:0]            req_last_tag,
   input  wire logic [bsu_pkg::TAG_W-1:0]            req_dept_tag,
   // response
   output      logic                                 rsp_strobe,
   output      logic [bsu_pkg::STATUS_W-1:0]         rsp_status,
   output      logic [bsu_pkg::TAG_W-1:0]            rsp_affected_id,
   output      logic [$clog2(CAPACITY+1)-1:0]        rsp_stored_count,
   // register port
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [bsu_pkg::CSR_AW-1:0]           paddr,
   input  wire logic [bsu_pkg::CSR_DW-1:0]           pwdata,
   output      logic [bsu_pkg::CSR_DW-1:0]           prdata,
   output      logic                                 pready
);

   import bsu_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int RIDX_W = $clog2(CAPACITY);
   localparam int JIDX_W = $clog2(JOURNAL_DEPTH);
   localparam int JCNT_W = $clog2(JOURNAL_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > QUOTA_W) ? CNT_W : QUOTA_W;

   localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [JCNT_W-1:0] JD_CNT   = JCNT_W'(JOURNAL_DEPTH);
   localparam logic [JIDX_W-1:0] JD_LAST  = JIDX_W'(JOURNAL_DEPTH - 1);

   // ---------------------------------------------------------------- csr
   logic [QUOTA_W-1:0] quota;

   bsu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .quota   (quota)
   );

   // ---------------------------------------------------------------- control state
   seq_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  rec_count_ff, rec_count_in;
   logic [JIDX_W-1:0] jr_head_ff, jr_head_in;
   logic [JCNT_W-1:0] jr_count_ff, jr_count_in;

   // latched request word (payload, no reset)
   logic [ACTION_W-1:0] act_ff;
   record_type          req_rec_ff;

   // response registers
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [CNT_W-1:0]    rsp_count_ff;

   logic              accept;
   logic [CNT_W-1:0]  rec_top;
   logic [JIDX_W-1:0] jr_prev;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // top of stack and newest journal slot; both stay put until the execute edge
   assign rec_top = rec_count_ff - 1'b1;
   assign jr_prev = (jr_head_ff == '0) ? JD_LAST : jr_head_ff - 1'b1;

   // ---------------------------------------------------------------- memories
   logic                          rec_wr_en;
   logic [RIDX_W-1:0]             rec_wr_addr;
   record_type                    rec_wr_data;
   logic [$bits(record_type)-1:0] rec_rd_raw;
   record_type                    rec_rd;

   logic                          jr_wr_en;
   jrnl_type                      jr_wr_data;
   logic [$bits(jrnl_type)-1:0]   jr_rd_raw;
   jrnl_type                      jr_rd;

   bsu_ram #(
      .WIDTH ($bits(record_type)),
      .DEPTH (CAPACITY)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (rec_wr_addr),
      .wr_data (rec_wr_data),
      .rd_en   (accept),
      .rd_addr (rec_top[RIDX_W-1:0]),
      .rd_data (rec_rd_raw)
   );

   bsu_ram #(
      .WIDTH ($bits(jrnl_type)),
      .DEPTH (JOURNAL_DEPTH)
   ) u_jr_ram (
      .clock   (clock),
      .wr_en   (jr_wr_en),
      .wr_addr (jr_head_ff),
      .wr_data (jr_wr_data),
      .rd_en   (accept),
      .rd_addr (jr_prev),
      .rd_data (jr_rd_raw)
   );

   assign rec_rd = record_type'(rec_rd_raw);
   assign jr_rd  = jrnl_type'(jr_rd_raw);

   // ---------------------------------------------------------------- execute
   logic rec_full;
   logic [JIDX_W-1:0] jr_next;
   logic [JCNT_W-1:0] jr_count_inc;

   assign rec_full = (CMP_W'(rec_count_ff) >= CMP_W'(quota)) || (rec_count_ff >= CAP_CNT);
   assign jr_next  = (jr_head_ff == JD_LAST) ? '0 : jr_head_ff + 1'b1;
   // journal full: oldest entry is overwritten, count saturates
   assign jr_count_inc = (jr_count_ff == JD_CNT) ? jr_count_ff : jr_count_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      rec_count_in  = rec_count_ff;
      jr_head_in    = jr_head_ff;
      jr_count_in   = jr_count_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = RES_NOTHING_UNDO;
      rsp_id_in     = '0;
      rec_wr_en     = 1'b0;
      rec_wr_addr   = rec_count_ff[RIDX_W-1:0];
      rec_wr_data   = req_rec_ff;
      jr_wr_en      = 1'b0;
      jr_wr_data    = '{kind: KIND_PUSH, rec: req_rec_ff};

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            case (act_ff)
               ACT_PUSH: begin
                  if (rec_full) begin
                     rsp_status_in = RES_FULL;
                  end else begin
                     rec_wr_en     = 1'b1;
                     jr_wr_en      = 1'b1;
                     jr_head_in    = jr_next;
                     jr_count_in   = jr_count_inc;
                     rec_count_in  = rec_count_ff + 1'b1;
                     rsp_status_in = RES_PUSHED;
                     rsp_id_in     = req_rec_ff.id;
                  end
               end
               ACT_POP: begin
                  if (rec_count_ff == '0) begin
                     rsp_status_in = RES_EMPTY;
                  end else begin
                     jr_wr_en      = 1'b1;
                     jr_wr_data    = '{kind: KIND_POP, rec: rec_rd};
                     jr_head_in    = jr_next;
                     jr_count_in   = jr_count_inc;
                     rec_count_in  = rec_top;
                     rsp_status_in = RES_POPPED;
                     rsp_id_in     = rec_rd.id;
                  end
               end
               ACT_UNDO: begin
                  if (jr_count_ff != '0) begin
                     jr_head_in  = jr_prev;
                     jr_count_in = jr_count_ff - 1'b1;
                     rsp_id_in   = jr_rd.rec.id;
                     if (jr_rd.kind == KIND_PUSH) begin
                        if (rec_count_ff != '0) begin
                           rec_count_in = rec_top;
                        end
                        rsp_status_in = RES_PUSH_UNDONE;
                     end else begin
                        // restore even above quota, never above capacity
                        if (rec_count_ff < CAP_CNT) begin
                           rec_wr_en    = 1'b1;
                           rec_wr_data  = jr_rd.rec;
                           rec_count_in = rec_count_ff + 1'b1;
                        end
                        rsp_status_in = RES_POP_UNDONE;
                     end
                  end
               end
               default: begin
                  rsp_status_in = RES_NOTHING_UNDO;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rec_count_ff  <= '0;
         jr_head_ff    <= '0;
         jr_count_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rec_count_ff  <= rec_count_in;
         jr_head_ff    <= jr_head_in;
         jr_count_ff   <= jr_count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff     <= req_action;
         req_rec_ff <= '{id: req_record_id, first: req_first_tag,
                         last: req_last_tag, dept: req_dept_tag};
      end
      if (rsp_strobe_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_count_ff  <= rec_count_in;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_affected_id  = rsp_id_ff;
   assign rsp_stored_count = rsp_count_ff;

   // ---------------------------------------------------------------- checks
   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == S_EXEC)
      else $error("response strobe without an execute cycle");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC)
      else $error("accepted word did not enter execute");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rec_count_ff <= CAP_CNT)
      else $error("record count above capacity");

   a_jr_bound: assert property (@(posedge clock) disable iff (reset)
      jr_count_ff <= JD_CNT)
      else $error("journal count above depth");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_stored_count == rec_count_ff)
      else $error("reported count differs from held count");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// testbench: directed and random push/pop/undo traffic for bounded_stack_with_undo_core,
// each response checked against a behavioral stack-and-journal predictor kept in the bench.
// Depends on bsu_pkg and the core RTL; reads no files.

module testbench;
   import bsu_pkg::*;

   localparam int CAPACITY      = 16;
   localparam int JOURNAL_DEPTH = 16;
   localparam int COUNT_W       = $clog2(CAPACITY + 1);
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 100;
   localparam int PHASE_WORDS   = 205;

   // action 3 is unused; the core must answer it like an empty undo
   localparam logic [ACTION_W-1:0] ACT_SPARE  = 2'd3;
   localparam logic [CSR_AW-1:0]   QUOTA_ADDR = {REG_QUOTA, 2'b00};

   // traffic flavors for the random bursts
   typedef enum int {
      MIX_FILL,
      MIX_UNWIND,
      MIX_REWIND,
      MIX_EVEN
   } traffic_mix_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TAG_W-1:0]    id;
      logic [COUNT_W-1:0]  count;
   } outcome_type;

   // ---------------------------------------------------------------- DUT signals
   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [ACTION_W-1:0]  req_action;
   logic [TAG_W-1:0]     req_record_id;
   logic [TAG_W-1:0]     req_first_tag;
   logic [TAG_W-1:0]     req_last_tag;
   logic [TAG_W-1:0]     req_dept_tag;
   logic                 rsp_strobe;
   logic [STATUS_W-1:0]  rsp_status;
   logic [TAG_W-1:0]     rsp_affected_id;
   logic [COUNT_W-1:0]   rsp_stored_count;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [CSR_AW-1:0]    paddr;
   logic [CSR_DW-1:0]    pwdata;
   logic [CSR_DW-1:0]    prdata;
   logic                 pready;

   bounded_stack_with_undo_core #(
      .CAPACITY      (CAPACITY),
      .JOURNAL_DEPTH (JOURNAL_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_record_id    (req_record_id),
      .req_first_tag    (req_first_tag),
      .req_last_tag     (req_last_tag),
      .req_dept_tag     (req_dept_tag),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_affected_id  (rsp_affected_id),
      .rsp_stored_count (rsp_stored_count),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // 20 ns clock
   always #10 clock = ~clock;

   // ---------------------------------------------------------------- predictor state
   // Own copy of the record stack, the circular undo journal and the quota.
   record_type          stack_mem [CAPACITY];
   int                  stack_depth;
   jrnl_type            undo_log [JOURNAL_DEPTH];
   int                  log_head;      // next journal slot to fill
   int                  log_fill;      // live journal entries
   logic [QUOTA_W-1:0]  quota_now;

   outcome_type         outcomes_due[$];   // one per accepted word, oldest first
   int                  mismatch_count = 0;
   int                  cycle_count = 0;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      // keep the log readable if the core is badly broken
      if (mismatch_count <= REPORT_LIMIT)
         $display("MISMATCH @%0t: %s", $time, what);
   endtask

   // Log a successful push or pop; a full journal silently drops its oldest entry.
   function automatic void journal_note(input logic kind, input record_type rec);
      undo_log[log_head].kind = kind;
      undo_log[log_head].rec  = rec;
      log_head = (log_head + 1) % JOURNAL_DEPTH;
      if (log_fill < JOURNAL_DEPTH)
         log_fill++;
   endfunction

   // Apply one word to the predicted state and return the response it must produce.
   function automatic outcome_type apply_action(input logic [ACTION_W-1:0] act,
                                                input record_type rec);
      outcome_type res;
      jrnl_type    ent;
      res.status = RES_NOTHING_UNDO;
      res.id     = '0;
      case (act)
         ACT_PUSH: begin
            // quota may exceed CAPACITY (5-bit register), so both bounds apply
            if (stack_depth >= quota_now || stack_depth >= CAPACITY) begin
               res.status = RES_FULL;
            end else begin
               stack_mem[stack_depth] = rec;
               stack_depth++;
               journal_note(KIND_PUSH, rec);
               res.status = RES_PUSHED;
               res.id     = rec.id;
            end
         end
         ACT_POP: begin
            if (stack_depth == 0) begin
               res.status = RES_EMPTY;
            end else begin
               stack_depth--;
               journal_note(KIND_POP, stack_mem[stack_depth]);
               res.status = RES_POPPED;
               res.id     = stack_mem[stack_depth].id;
            end
         end
         ACT_UNDO: begin
            if (log_fill != 0) begin
               log_head = (log_head + JOURNAL_DEPTH - 1) % JOURNAL_DEPTH;
               log_fill--;
               ent    = undo_log[log_head];
               res.id = ent.rec.id;
               if (ent.kind == KIND_PUSH) begin
                  if (stack_depth != 0)
                     stack_depth--;
                  res.status = RES_PUSH_UNDONE;
               end else begin
                  // restored even when it lands above the current quota
                  if (stack_depth < CAPACITY) begin
                     stack_mem[stack_depth] = ent.rec;
                     stack_depth++;
                  end
                  res.status = RES_POP_UNDONE;
               end
            end
         end
         default: begin
            // spare action: no state change, reported as nothing to undo
         end
      endcase
      res.count = stack_depth[COUNT_W-1:0];
      return res;
   endfunction

   // ---------------------------------------------------------------- response check
   // Results can't be held off, so every strobe is consumed at the edge it ends on.
   always @(posedge clock) begin : response_check
      outcome_type due;
      if (!reset && rsp_strobe === 1'b1) begin
         if (outcomes_due.size() == 0) begin
            report_mismatch($sformatf("response with no word pending: status %0d id %h",
                                      rsp_status, rsp_affected_id));
         end else begin
            due = outcomes_due.pop_front();
            if (rsp_status !== due.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, due.status));
            if (rsp_affected_id !== due.id)
               report_mismatch($sformatf("affected id %h, expected %h",
                                         rsp_affected_id, due.id));
            if (rsp_stored_count !== due.count)
               report_mismatch($sformatf("stored count %0d, expected %0d",
                                         rsp_stored_count, due.count));
         end
      end
   end

   // watchdog: any hang ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still pending",
                  cycle_count, outcomes_due.size());
         $display("** bounded_stack_with_undo_core: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus helpers
   // Present one word at the falling edge and hold it until start & !busy is seen at a
   // rising edge; start stays high afterwards so back-to-back words need no extra step.
   task automatic issue_word(input logic [ACTION_W-1:0] act, input record_type rec);
      @(negedge clock);
      start         <= 1'b1;
      req_action    <= act;
      req_record_id <= rec.id;
      req_first_tag <= rec.first;
      req_last_tag  <= rec.last;
      req_dept_tag  <= rec.dept;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      outcomes_due.push_back(apply_action(act, rec));
   endtask

   // Drop start before the next word; n sets the length of the gap, and zero leaves start high.
   task automatic rest_cycles(input int n);
      if (n > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Stop sending and let every outstanding response come back.
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (outcomes_due.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_read_expect();
      logic [CSR_DW-1:0] got;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= QUOTA_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (pready !== 1'b1);
      got = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== {{(CSR_DW - QUOTA_W){1'b0}}, quota_now})
         report_mismatch($sformatf("quota reads %h, expected %0d", got, quota_now));
   endtask

   // Quota is only changed with the core idle; each write is read back.
   task automatic csr_write_quota(input logic [QUOTA_W-1:0] value);
      wait_idle();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= QUOTA_ADDR;
      pwdata  <= {{(CSR_DW - QUOTA_W){1'b0}}, value};
      @(negedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (pready !== 1'b1);
      quota_now = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      csr_read_expect();
   endtask

   function automatic record_type random_record();
      record_type rec;
      rec.id    = $urandom;
      rec.first = $urandom;
      rec.last  = $urandom;
      rec.dept  = $urandom;
      return rec;
   endfunction

   // mostly back-to-back or short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [ACTION_W-1:0] pick_action(input traffic_mix_type mix);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3)
         return ACT_SPARE;
      case (mix)
         MIX_FILL:   return (r < 75) ? ACT_PUSH : (r < 90) ? ACT_POP : ACT_UNDO;
         MIX_UNWIND: return (r < 20) ? ACT_PUSH : (r < 90) ? ACT_POP : ACT_UNDO;
         MIX_REWIND: return (r < 12) ? ACT_PUSH : (r < 18) ? ACT_POP : ACT_UNDO;
         default:    return (r < 36) ? ACT_PUSH : (r < 68) ? ACT_POP : ACT_UNDO;
      endcase
   endfunction

   // ---------------------------------------------------------------- tests
   // Fresh core: quota at its reset value, pop and undo have nothing to work on.
   task automatic test_after_reset();
      csr_read_expect();
      issue_word(ACT_POP, random_record());
      rest_cycles(pick_gap());
      issue_word(ACT_UNDO, random_record());
      rest_cycles(pick_gap());
      issue_word(ACT_SPARE, random_record());
      rest_cycles(pick_gap());
   endtask

   // All-zero / all-one / patterned records, then unwind the whole journal
   // (pop undone, three pushes undone, then an empty journal).
   task automatic test_field_extremes();
      record_type pattern;
      pattern = {32'h5A5A_A5A5, 32'hA5A5_5A5A, 32'h0000_FFFF, 32'hFFFF_0000};
      issue_word(ACT_PUSH, '0);
      issue_word(ACT_PUSH, '1);
      rest_cycles(1);
      issue_word(ACT_PUSH, pattern);
      issue_word(ACT_POP, random_record());
      rest_cycles(2);
      repeat (5) begin
         issue_word(ACT_UNDO, random_record());
         rest_cycles(pick_gap());
      end
   endtask

   // Quota of one and of zero, and an undone pop landing above a lowered quota.
   task automatic test_quota_edges();
      csr_write_quota(5'd1);
      issue_word(ACT_PUSH, random_record());
      issue_word(ACT_PUSH, random_record());   // rejected: full
      issue_word(ACT_POP, random_record());
      csr_write_quota(5'd0);
      issue_word(ACT_PUSH, random_record());   // zero quota rejects everything
      csr_write_quota(5'd2);
      issue_word(ACT_PUSH, random_record());
      issue_word(ACT_PUSH, random_record());
      issue_word(ACT_POP, random_record());
      csr_write_quota(5'd1);
      issue_word(ACT_UNDO, random_record());   // restores to two records
      issue_word(ACT_PUSH, random_record());   // still over quota
   endtask

   // Random bursts of one flavor each; some bursts run with no gaps at all.
   task automatic run_traffic(input int n_words);
      int                  counted;
      int                  burst;
      int                  k;
      bit                  quiet;
      traffic_mix_type     mix;
      logic [ACTION_W-1:0] act;
      counted = 0;
      while (counted < n_words) begin
         mix   = traffic_mix_type'($urandom_range(0, 3));
         burst = $urandom_range(4, 24);
         quiet = ($urandom_range(0, 3) == 0);
         for (k = 0; k < burst && counted < n_words; k++) begin
            act = pick_action(mix);
            issue_word(act, random_record());
            if (act != ACT_SPARE)
               counted++;
            rest_cycles(quiet ? 0 : pick_gap());
         end
         // occasionally let the pipeline run dry before carrying on
         if ($urandom_range(0, 15) == 0)
            wait_idle();
      end
   endtask

   // Random traffic under several quotas; the stack carries over between phases,
   // so lowering the quota can leave it above the new limit.
   task automatic test_quota_sweep();
      logic [QUOTA_W-1:0] quotas [6];
      int                 p;
      quotas[0] = 5'd16;
      quotas[1] = 5'd31;
      quotas[2] = 5'd1;
      quotas[3] = 5'd7;
      quotas[4] = QUOTA_W'($urandom_range(2, 15));
      quotas[5] = 5'd12;
      for (p = 0; p < 6; p++) begin
         csr_write_quota(quotas[p]);
         run_traffic(PHASE_WORDS);
      end
   endtask

   // ---------------------------------------------------------------- main sequence
   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_action    = ACT_PUSH;
      req_record_id = '0;
      req_first_tag = '0;
      req_last_tag  = '0;
      req_dept_tag  = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      stack_depth   = 0;
      log_head      = 0;
      log_fill      = 0;
      quota_now     = QUOTA_RESET;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_field_extremes();
      test_quota_edges();
      test_quota_sweep();

      wait_idle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("** bounded_stack_with_undo_core: PASSED **");
      else
         $display("** bounded_stack_with_undo_core: FAILED **");
      $finish;
   end

endmodule
